// ----- rtl/multipath_next_hop_selector_macros.svh -----
// Assertion macros for the multipath next-hop selector.
`ifndef MULTIPATH_NEXT_HOP_SELECTOR_MACROS_SVH
`define MULTIPATH_NEXT_HOP_SELECTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MNHS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mnhs assertion failed");
`define MNHS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("mnhs assertion failed");
`else
`define MNHS_ASSERT(lbl, prop)
`define MNHS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/mnhs_pkg.sv -----
// Shared types and constants of the multipath next-hop selector.
`timescale 1ns / 1ps
package mnhs_pkg;
	localparam int MAX_PATHS_DEF = 16;
	localparam int CW = 5;          // path count width
	localparam int MOD_W = 20;      // divisor / remainder width

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	localparam logic [1:0] POL_RR   = 2'd0;
	localparam logic [1:0] POL_HASH = 2'd1;
	localparam logic [1:0] POL_LAT  = 2'd2;

	localparam logic [1:0] OUT_NORMAL   = 2'd0;
	localparam logic [1:0] OUT_FALLBACK = 2'd1;
	localparam logic [1:0] OUT_EXPLORED = 2'd2;
	localparam logic [1:0] OUT_EMPTY    = 2'd3;

	localparam logic [2:0] REG_POLICY  = 3'd0;
	localparam logic [2:0] REG_COUNT   = 3'd1;
	localparam logic [2:0] REG_SKIP    = 3'd2;
	localparam logic [2:0] REG_QOS     = 3'd3;
	localparam logic [2:0] REG_MARGIN  = 3'd4;
	localparam logic [2:0] REG_EXPLORE = 3'd5;

	localparam logic [31:0]    XS_SEED   = 32'h9E3779B9;
	localparam logic [31:0]    SALT_STEP = 32'h0000_9E37;
	localparam logic [MOD_W-1:0] PPM_SCALE = 20'd1000000;
	// floor(2^32 / 1e6): the quotient estimate is exact or one low
	localparam logic [12:0]    PPM_RECIP = 13'd4294;

	typedef struct packed {
		logic [15:0] ident;
		logic [31:0] rtt;
		logic        healthy;
		logic [7:0]  qos;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic [31:0]      dividend;
		logic [MOD_W-1:0] divisor;
	} mod_req_t;

	function automatic logic [31:0] xs_step(input logic [31:0] s);
		logic [31:0] x;
		x = s;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction
endpackage

// ----- rtl/mnhs_table.sv -----
// Path table: one write port, one registered read port.
`timescale 1ns / 1ps
module mnhs_table #(
	parameter int MAX_PATHS = mnhs_pkg::MAX_PATHS_DEF,
	parameter int AW = 4
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  mnhs_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output mnhs_pkg::entry_t rd_data
);
	import mnhs_pkg::*;

	entry_t mem [MAX_PATHS];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ----- rtl/mnhs_mod.sv -----
// Iterative remainder unit: 32-bit dividend, one quotient bit per cycle.
`timescale 1ns / 1ps
module mnhs_mod (
	input  logic               clk,
	input  logic               arst_n,
	input  mnhs_pkg::mod_req_t req,
	output logic               done,
	output logic [mnhs_pkg::MOD_W-1:0] rem
);
	import mnhs_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [31:0]      dvd_q;
	logic [MOD_W-1:0] rem_q;
	logic [MOD_W-1:0] div_q;
	logic [MOD_W:0]   shifted;
	logic [MOD_W:0]   trial;

	assign shifted = {rem_q, dvd_q[31]};
	assign trial   = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= (shifted >= {1'b0, div_q}) ? trial[MOD_W-1:0] : shifted[MOD_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

// ----- rtl/multipath_next_hop_selector.sv -----
// Multipath next-hop selector: path table, policy sequencer and result register.
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per command.
//   A write command stores one table entry and gives no result. A select
//   command gives exactly one result on the output channel
//   (out_valid/out_ready): chosen_path and outcome.
//   Select steps: round robin and flow hash run the remainder unit, then one
//   table read per entry, pipelined; latency aware scans the table, then draws
//   for exploration, and when exploring adds one remainder pass and a second
//   table scan. An empty table goes straight to the result with no table read.
//   One command is in work at a time; in_ready is high when the sequencer is
//   idle, even while the previous result waits in the output register.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready; the
//   user must write it only while the block is idle, which the block does not enforce.
//   Reset clears configuration, rotation counter and salt; table contents
//   are undefined until written. A stalled receiver holds the result; a
//   finished select waits for the output register to free up.
`timescale 1ns / 1ps
`include "multipath_next_hop_selector_macros.svh"
module multipath_next_hop_selector #(
	parameter int MAX_PATHS = mnhs_pkg::MAX_PATHS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [3:0]  entry_index,
	input  logic [15:0] path_ident,
	input  logic [31:0] rtt_us,
	input  logic        healthy,
	input  logic [7:0]  traffic_class,
	input  logic [31:0] pkt_hash,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] chosen_path,
	output logic [1:0]  outcome,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import mnhs_pkg::*;

	localparam int AW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_LAT  = 3'd3;
	localparam logic [2:0] ST_DEC  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;
	localparam logic [2:0] ST_PPM  = 3'd6;

	localparam logic [1:0] MT_RR   = 2'd0;
	localparam logic [1:0] MT_HASH = 2'd1;
	localparam logic [1:0] MT_EXP2 = 2'd3;

	// configuration
	logic [1:0]  policy_q;
	logic [CW-1:0] count_q;
	logic        skip_q;
	logic        prefer_q;
	logic [31:0] margin_q;
	logic [19:0] ppm_q;

	logic [2:0]  state_q;
	logic [1:0]  tag_q;
	logic [31:0] rot_q;
	logic [31:0] salt_q;
	logic [31:0] hash_q;
	logic [31:0] x_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] n_eff;
	mod_req_t    mod_req_q;
	logic        mod_done;
	logic [MOD_W-1:0] mod_rem;
	logic        mod_go;
	logic [31:0] mod_dvd;
	logic [MOD_W-1:0] mod_dvs;

	// exploration draw, remainder by 1e6
	logic [44:0] prod_q;
	logic [12:0] ppm_quo;
	logic [20:0] ppm_sub;
	logic [20:0] ppm_r;
	logic [20:0] ppm_rem;
	logic        ppm_hit;

	// scan engine
	logic [CW-1:0] pos_q;
	logic [CW-1:0] issue_cnt_q;
	logic [CW-1:0] check_cnt_q;
	logic          rd_v_s1;
	logic [CW-1:0] rd_pos_s1;
	logic          scan_any_q;
	logic          scan_expl_q;
	logic [15:0]   first_ident_q;
	logic          issue;
	logic          last_check;
	logic          match;
	entry_t        rd_data;
	entry_t        wr_data;
	logic          wr_en;

	// latency-aware tracking
	logic          have_q;
	logic [CW-1:0] best_pos_q;
	logic [31:0]   best_rtt_q;
	logic [7:0]    best_qos_q;
	logic [15:0]   best_ident_q;
	logic [31:0]   min_rtt_q;
	logic [15:0]   min_ident_q;
	logic [32:0]   lim;
	logic          take_best;
	logic          take_min;

	logic [31:0] seed;
	logic [31:0] x1;
	logic        sel_acc;

	// result
	logic [15:0] res_ident_q;
	logic [1:0]  res_outcome_q;
	logic        out_valid_q;
	logic [15:0] out_ident_q;
	logic [1:0]  out_outcome_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign sel_acc   = in_valid && in_ready && (command == CMD_SELECT);
	assign n_eff     = (32'(count_q) > MAX_PATHS) ? CW'(MAX_PATHS) : count_q;

	assign wr_en = in_valid && in_ready && (command == CMD_WRITE) &&
		(32'(entry_index) < MAX_PATHS);
	assign wr_data = '{ident: path_ident, rtt: rtt_us, healthy: healthy, qos: traffic_class};

	assign issue = ((state_q == ST_SCAN) || (state_q == ST_LAT)) && (issue_cnt_q != n_q);
	assign last_check = (check_cnt_q == n_q - CW'(1));
	assign match = scan_any_q ||
		(rd_data.healthy && !(scan_expl_q && (rd_pos_s1 == best_pos_q)));

	assign lim = {1'b0, best_rtt_q} + {1'b0, margin_q};
	assign take_best = rd_data.healthy && (!have_q || (rd_data.rtt < best_rtt_q) ||
		(prefer_q && ({1'b0, rd_data.rtt} <= lim) && (rd_data.qos != 8'd0) &&
		 (best_qos_q == 8'd0)));
	assign take_min = (check_cnt_q == '0) || (rd_data.rtt < min_rtt_q);

	assign seed = ((hash_q ^ salt_q) == 32'd0) ? XS_SEED : (hash_q ^ salt_q);
	assign x1   = xs_step(seed);

	// x mod 1e6: quotient from the registered reciprocal product, one fix-up
	assign ppm_quo = prod_q[44:32];
	assign ppm_sub = {8'd0, ppm_quo} * {1'b0, PPM_SCALE};
	assign ppm_r   = x_q[20:0] - ppm_sub;
	assign ppm_rem = (ppm_r >= {1'b0, PPM_SCALE}) ? (ppm_r - {1'b0, PPM_SCALE}) : ppm_r;
	assign ppm_hit = (ppm_rem < {1'b0, ppm_q});

	always_comb begin
		mod_go  = 1'b0;
		mod_dvd = rot_q;
		mod_dvs = MOD_W'(n_eff);
		case (state_q)
			ST_IDLE: begin
				if (sel_acc && (n_eff != '0) &&
						((policy_q == POL_RR) || (policy_q == POL_HASH))) begin
					mod_go  = 1'b1;
					mod_dvd = (policy_q == POL_HASH) ? pkt_hash : rot_q;
				end
			end
			ST_PPM: begin
				if (ppm_hit) begin
					mod_go  = 1'b1;
					mod_dvd = xs_step(x_q);
					mod_dvs = MOD_W'(n_q);
				end
			end
			default: begin
			end
		endcase
	end

	mnhs_table #(.MAX_PATHS(MAX_PATHS), .AW(AW)) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(entry_index)),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (AW'(pos_q)),
		.rd_data (rd_data)
	);

	mnhs_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req_q),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_RR;
			count_q  <= '0;
			skip_q   <= 1'b0;
			prefer_q <= 1'b0;
			margin_q <= '0;
			ppm_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POLICY:  policy_q <= cfg_data[1:0];
				REG_COUNT:   count_q  <= cfg_data[CW-1:0];
				REG_SKIP:    skip_q   <= cfg_data[0];
				REG_QOS:     prefer_q <= cfg_data[0];
				REG_MARGIN:  margin_q <= cfg_data;
				REG_EXPLORE: ppm_q    <= cfg_data[19:0];
				default: begin
				end
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rot_q       <= '0;
			salt_q      <= '0;
			mod_req_q   <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mod_req_q   <= '{start: mod_go, dividend: mod_dvd, divisor: mod_dvs};
			rd_v_s1     <= issue;
			out_valid_q <= (out_valid_q && !out_ready) || (state_q == ST_DONE);
			case (state_q)
				ST_IDLE: begin
					if (sel_acc) begin
						if (n_eff == '0) begin
							state_q <= ST_DONE;
						end else begin
							case (policy_q)
								POL_RR: begin
									rot_q   <= rot_q + 32'd1;
									state_q <= ST_MOD;
								end
								POL_HASH: state_q <= ST_MOD;
								default:  state_q <= ST_LAT;
							endcase
						end
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_v_s1 && (match || last_check)) begin
						if (match && scan_expl_q) begin
							salt_q <= salt_q + SALT_STEP;
						end
						state_q <= ST_DONE;
					end
				end
				ST_LAT: begin
					if (rd_v_s1 && last_check) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (have_q && (ppm_q != 20'd0)) begin
						state_q <= ST_PPM;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_PPM: begin
					state_q <= ppm_hit ? ST_MOD : ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		rd_pos_s1 <= pos_q;
		if (issue) begin
			pos_q       <= (pos_q == n_q - CW'(1)) ? '0 : pos_q + CW'(1);
			issue_cnt_q <= issue_cnt_q + CW'(1);
		end
		case (state_q)
			ST_IDLE: begin
				n_q         <= n_eff;
				hash_q      <= pkt_hash;
				tag_q       <= (policy_q == POL_RR) ? MT_RR : MT_HASH;
				pos_q       <= '0;
				issue_cnt_q <= '0;
				check_cnt_q <= '0;
				have_q      <= 1'b0;
				res_ident_q   <= 16'd0;
				res_outcome_q <= OUT_EMPTY;
			end
			ST_MOD: begin
				if (mod_done) begin
					pos_q       <= mod_rem[CW-1:0];
					issue_cnt_q <= '0;
					check_cnt_q <= '0;
					scan_any_q  <= (tag_q == MT_HASH) && !skip_q;
					scan_expl_q <= (tag_q == MT_EXP2);
				end
			end
			ST_SCAN: begin
				if (rd_v_s1) begin
					check_cnt_q <= check_cnt_q + CW'(1);
					if (check_cnt_q == '0) begin
						first_ident_q <= rd_data.ident;
					end
					if (match) begin
						res_ident_q   <= rd_data.ident;
						res_outcome_q <= scan_expl_q ? OUT_EXPLORED : OUT_NORMAL;
					end else if (last_check) begin
						if (scan_expl_q) begin
							res_ident_q   <= best_ident_q;
							res_outcome_q <= OUT_NORMAL;
						end else begin
							res_ident_q   <= (check_cnt_q == '0) ? rd_data.ident
								: first_ident_q;
							res_outcome_q <= OUT_FALLBACK;
						end
					end
				end
			end
			ST_LAT: begin
				if (rd_v_s1) begin
					check_cnt_q <= check_cnt_q + CW'(1);
					if (take_best) begin
						have_q       <= 1'b1;
						best_pos_q   <= rd_pos_s1;
						best_rtt_q   <= rd_data.rtt;
						best_qos_q   <= rd_data.qos;
						best_ident_q <= rd_data.ident;
					end
					if (take_min) begin
						min_rtt_q   <= rd_data.rtt;
						min_ident_q <= rd_data.ident;
					end
				end
			end
			ST_DEC: begin
				x_q    <= x1;
				prod_q <= {13'd0, x1} * {32'd0, PPM_RECIP};
				tag_q  <= MT_EXP2;
				if (!have_q) begin
					res_ident_q   <= min_ident_q;
					res_outcome_q <= OUT_FALLBACK;
				end else begin
					res_ident_q   <= best_ident_q;
					res_outcome_q <= OUT_NORMAL;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_ident_q   <= res_ident_q;
					out_outcome_q <= res_outcome_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign chosen_path = out_ident_q;
	assign outcome     = out_outcome_q;

	`MNHS_ASSERT(a_issue_bound, (state_q == ST_SCAN) |-> (issue_cnt_q <= n_q))
	`MNHS_ASSERT(a_mod_done_state, mod_done |-> (state_q == ST_MOD))
	`MNHS_ASSERT(a_empty_select, (sel_acc && (n_eff == '0)) |=> ((state_q == ST_DONE) && (res_outcome_q == OUT_EMPTY)))
	`MNHS_ASSERT(a_rot_only_rr, !(sel_acc && (policy_q == POL_RR) && (n_eff != '0)) |=> $stable(rot_q))
endmodule

// ----- sim/tb_top.sv -----
// Testbench for the multipath next-hop selector: directed and random selects against a predictor.
`timescale 1ns / 1ps
module tb_top;
	import mnhs_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 200;

	typedef struct packed {
		logic [15:0] path;
		logic [1:0]  oc;
	} pick_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [3:0]  entry_index;
	logic [15:0] path_ident;
	logic [31:0] rtt_us;
	logic        healthy;
	logic [7:0]  traffic_class;
	logic [31:0] pkt_hash;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] chosen_path;
	logic [1:0]  outcome;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	// predictor state
	entry_t      paths [16];
	logic [31:0] rot_ctr;
	logic [31:0] salt;
	logic [1:0]  m_policy;
	logic [4:0]  m_count;
	logic        m_skip;
	logic        m_qos;
	logic [31:0] m_margin;
	logic [19:0] m_ppm;

	pick_t       pending_picks [$];
	int          mismatches;
	int          quiet_cycles;
	bit          no_idle;

	multipath_next_hop_selector uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .entry_index(entry_index), .path_ident(path_ident),
		.rtt_us(rtt_us), .healthy(healthy), .traffic_class(traffic_class),
		.pkt_hash(pkt_hash),
		.out_valid(out_valid), .out_ready(out_ready),
		.chosen_path(chosen_path), .outcome(outcome),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] xorshift(input logic [31:0] v);
		logic [31:0] x;
		x = v;
		x ^= x << 13;
		x ^= x >> 17;
		x ^= x << 5;
		return x;
	endfunction

	function automatic int first_healthy(input int start, input int n);
		for (int i = 0; i < n; i++) begin
			if (paths[(start + i) % n].healthy)
				return (start + i) % n;
		end
		return -1;
	endfunction

	// Next-hop choice for one select; updates counter and salt.
	function automatic pick_t choose_path(input logic [31:0] hash);
		pick_t       p;
		int          n, k, best, start, chosen;
		bit          have;
		logic [32:0] lim;
		logic [31:0] s;
		p.oc = OUT_NORMAL;
		n = (m_count > 16) ? 16 : m_count;
		if (n == 0) begin
			p.path = 16'd0;
			p.oc = OUT_EMPTY;
			return p;
		end
		if (m_policy == POL_RR) begin
			start = rot_ctr % n;
			rot_ctr = rot_ctr + 1;
			k = first_healthy(start, n);
			if (k < 0) begin
				chosen = start;
				p.oc = OUT_FALLBACK;
			end else begin
				chosen = k;
			end
		end else if (m_policy == POL_HASH) begin
			chosen = hash % n;
			if (m_skip) begin
				k = first_healthy(chosen, n);
				if (k < 0)
					p.oc = OUT_FALLBACK;
				else
					chosen = k;
			end
		end else begin
			best = 0;
			have = 0;
			for (int i = 0; i < n; i++) begin
				if (!paths[i].healthy)
					continue;
				if (!have || paths[i].rtt < paths[best].rtt) begin
					best = i;
					have = 1;
				end else if (m_qos) begin
					lim = {1'b0, paths[best].rtt} + {1'b0, m_margin};
					if ({1'b0, paths[i].rtt} <= lim && paths[i].qos != 0 &&
							paths[best].qos == 0)
						best = i;
				end
			end
			if (!have) begin
				best = 0;
				for (int i = 1; i < n; i++)
					if (paths[i].rtt < paths[best].rtt)
						best = i;
				p.oc = OUT_FALLBACK;
			end else if (m_ppm != 0) begin
				s = hash ^ salt;
				if (s == 0)
					s = XS_SEED;
				s = xorshift(s);
				if ((s % 32'd1000000) < m_ppm) begin
					s = xorshift(s);
					start = s % n;
					for (int i = 0; i < n; i++) begin
						k = (start + i) % n;
						if (k != best && paths[k].healthy) begin
							salt = salt + SALT_STEP;
							best = k;
							p.oc = OUT_EXPLORED;
							break;
						end
					end
				end
			end
			chosen = best;
		end
		p.path = paths[chosen].ident;
		return p;
	endfunction

	task automatic send_item(input logic cmd, input logic [3:0] idx, input logic [15:0] id,
			input logic [31:0] rtt, input logic h, input logic [7:0] q,
			input logic [31:0] hash);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		entry_index <= idx;
		path_ident <= id;
		rtt_us <= rtt;
		healthy <= h;
		traffic_class <= q;
		pkt_hash <= hash;
		do @(posedge clk); while (!in_ready);
		if (cmd == CMD_WRITE)
			paths[idx] = '{ident: id, rtt: rtt, healthy: h, qos: q};
		else
			pending_picks.push_back(choose_path(hash));
	endtask

	// Pause the sender until every pick is back, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_POLICY:  m_policy = data[1:0];
			REG_COUNT:   m_count = data[4:0];
			REG_SKIP:    m_skip = data[0];
			REG_QOS:     m_qos = data[0];
			REG_MARGIN:  m_margin = data;
			REG_EXPLORE: m_ppm = data[19:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [1:0] pol, input logic [4:0] cnt, input logic sk,
			input logic qo, input logic [31:0] mg, input logic [19:0] pp);
		drain();
		write_reg(REG_POLICY, 32'(pol));
		write_reg(REG_COUNT, 32'(cnt));
		write_reg(REG_SKIP, 32'(sk));
		write_reg(REG_QOS, 32'(qo));
		write_reg(REG_MARGIN, mg);
		write_reg(REG_EXPLORE, 32'(pp));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_rtt();
		int r;
		r = $urandom_range(0, 3);
		if (r < 2)
			return $urandom_range(0, 15);
		if (r == 2)
			return $urandom();
		return 32'hFFFF_FFF0 | $urandom_range(0, 15);
	endfunction

	task automatic rand_write(input int health_pct);
		send_item(CMD_WRITE, 4'($urandom()), 16'($urandom()), rand_rtt(),
			$urandom_range(0, 99) < health_pct,
			($urandom_range(0, 1) != 0) ? 8'($urandom()) : 8'd0, $urandom());
	endtask

	task automatic rand_select();
		send_item(CMD_SELECT, 4'($urandom()), 16'($urandom()), $urandom(), 1'($urandom()),
			8'($urandom()), ($urandom_range(0, 9) == 0) ? salt : $urandom());
	endtask

	task automatic test_empty_table();
		send_item(CMD_SELECT, 4'd0, 16'd0, 32'd0, 1'b0, 8'd0, 32'hFFFF_FFFF);
		send_item(CMD_SELECT, 4'hF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 32'd0);
	endtask

	task automatic test_fill_table();
		for (int i = 0; i < 16; i++)
			send_item(CMD_WRITE, 4'(i), (i == 0) ? 16'hFFFF : 16'(i * 7 + 1),
				(i == 3) ? 32'hFFFF_FFFF : (i == 5) ? 32'd0 : 32'(i % 4 + 2),
				i[0], (i == 2) ? 8'hFF : 8'(i % 3), 32'd0);
	endtask

	task automatic test_policies();
		set_all(POL_RR, 5'd16, 1'b0, 1'b0, 32'd0, 20'd0);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, 32'd0);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, 32'd0);
		set_all(POL_HASH, 5'd31, 1'b1, 1'b0, 32'd0, 20'd0);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, 32'hFFFF_FFFF);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, 32'd4);
		set_all(POL_HASH, 5'd7, 1'b0, 1'b0, 32'd0, 20'd0);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, 32'd2);
		set_all(POL_LAT, 5'd16, 1'b1, 1'b1, 32'hFFFF_FFFF, 20'd0);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, 32'd0);
		// hash equal to salt gives a zero seed
		set_all(2'd3, 5'd16, 1'b0, 1'b1, 32'd1, 20'd1000000);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, salt);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, 32'h1234_5678);
		set_all(POL_LAT, 5'd16, 1'b0, 1'b0, 32'd0, 20'hFFFFF);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, 32'hFFFF_FFFF);
		// only one healthy path: exploration finds no other
		set_all(POL_LAT, 5'd2, 1'b0, 1'b0, 32'd0, 20'hFFFFF);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, 32'd9);
		// nothing healthy in use
		set_all(POL_LAT, 5'd1, 1'b1, 1'b0, 32'd0, 20'd0);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, 32'd1);
		set_all(POL_RR, 5'd1, 1'b0, 1'b0, 32'd0, 20'd0);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, 32'd1);
		set_all(POL_HASH, 5'd1, 1'b1, 1'b0, 32'd0, 20'd0);
		send_item(CMD_SELECT, '0, '0, '0, 1'b0, '0, 32'd1);
	endtask

	task automatic test_random_phases();
		int health_pct;
		logic [31:0] mg;
		logic [19:0] pp;
		logic [4:0]  cnt;
		for (int ph = 0; ph < 15; ph++) begin
			case ($urandom_range(0, 3))
				0: mg = 32'd0;
				1: mg = 32'hFFFF_FFFF;
				2: mg = $urandom_range(0, 8);
				default: mg = $urandom();
			endcase
			case ($urandom_range(0, 4))
				0: pp = 20'd0;
				1: pp = 20'd1000000;
				2: pp = 20'hFFFFF;
				3: pp = 20'($urandom_range(1, 999999));
				default: pp = 20'($urandom());
			endcase
			case ($urandom_range(0, 9))
				0: cnt = 5'd0;
				1: cnt = 5'($urandom_range(17, 31));
				2: cnt = 5'd16;
				default: cnt = 5'($urandom_range(1, 16));
			endcase
			set_all(2'($urandom_range(0, 3)), cnt, 1'($urandom()), 1'($urandom()), mg, pp);
			no_idle = (ph % 5 == 4);
			health_pct = (ph % 4 == 3) ? 10 : 70;
			for (int i = 0; i < 110; i++) begin
				if ($urandom_range(0, 99) < 30)
					rand_write(health_pct);
				else
					rand_select();
			end
			no_idle = 0;
		end
	endtask

	// receiver: random back pressure
	initial begin
		int g;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			g = gap_len();
			if (!no_idle && g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_picks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result path=%h outcome=%0d", chosen_path, outcome);
			end else begin
				if (chosen_path !== pending_picks[0].path ||
						outcome !== pending_picks[0].oc) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: exp path=%h outcome=%0d, got path=%h outcome=%0d",
							pending_picks[0].path, pending_picks[0].oc, chosen_path, outcome);
				end
				void'(pending_picks.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		quiet_cycles = 0;
		no_idle = 0;
		rot_ctr = '0;
		salt = '0;
		m_policy = POL_RR;
		m_count = '0;
		m_skip = 1'b0;
		m_qos = 1'b0;
		m_margin = '0;
		m_ppm = '0;
		foreach (paths[i]) paths[i] = '0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		command <= CMD_WRITE;
		entry_index <= '0;
		path_ident <= '0;
		rtt_us <= '0;
		healthy <= 1'b0;
		traffic_class <= '0;
		pkt_hash <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_fill_table();
		test_policies();
		test_random_phases();
		drain();
		if (mismatches == 0 && pending_picks.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
